// ===== src/fslm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fslm_pkg
// shared types and constants of the frame sequence loss monitor
// ----------------------------------------------------------------------------
`default_nettype none

package fslm_pkg;

   localparam int SLOT_COUNT = 4;
   localparam int PORT_COUNT = 8;
   localparam int SEQ_DEPTH  = SLOT_COUNT * PORT_COUNT;
   localparam int PORT_AW    = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
   localparam int SEQ_AW     = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;

   localparam logic [15:0] MAX_LEN_RESET = 16'd512;

   typedef enum logic [1:0] {
      REQ_FRAME  = 2'd0,
      REQ_QUERY  = 2'd1,
      REQ_PERIOD = 2'd2,
      REQ_IGNORE = 2'd3
   } req_kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } fslm_state_type;

   // per port record held in the port memory
   typedef struct packed {
      logic [31:0] stamp;
      logic [31:0] seen_tag;
      logic [15:0] length;
      logic [31:0] loss;
      logic [31:0] good;
      logic [31:0] overlen;
   } port_rec_type;

   typedef struct packed {
      logic valid;
      logic last_valid;
      logic processed;
   } mark_type;

   typedef struct packed {
      req_kind_type        kind;
      logic                slot_ok;
      logic                port_ok;
      logic [PORT_AW-1:0]  port;
      logic [SEQ_AW-1:0]   seq_idx;
      logic [15:0]         fcount;
      logic [15:0]         plen;
      logic [31:0]         tcount;
   } item_type;

   typedef struct packed {
      logic rec_we;
      logic seq_we;
      logic mark_we;
      logic clr_processed;
   } upd_ctl_type;

   typedef struct packed {
      logic        accepted;
      logic        frame_ok;
      logic        port_data_valid;
      logic        stale_dropped;
      logic [31:0] port_time_tag;
      logic [15:0] port_frame_length;
      logic [31:0] lost_frames;
      logic [31:0] good_frames;
      logic [31:0] length_errors;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/fslm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fslm_ram
// simple dual port synchronous ram, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module fslm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/fslm_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fslm_update
// modify step: new port record, marks and result word for one item
// ----------------------------------------------------------------------------
`default_nettype none

module fslm_update
   import fslm_pkg::*;
(
   input  wire item_type     item,
   input  wire port_rec_type rd_rec,
   input  wire logic [15:0]  prev_count,
   input  wire mark_type     marks_in,
   input  wire logic [15:0]  max_len,
   output port_rec_type      wr_rec,
   output mark_type          marks_out,
   output upd_ctl_type       ctl,
   output rsp_type           rsp
);

   logic [15:0] next_count;

   assign next_count = prev_count + 16'd1;

   always_comb begin
      wr_rec    = rd_rec;
      marks_out = marks_in;
      ctl       = '0;
      rsp       = '0;
      unique case (item.kind)
         REQ_FRAME: begin
            if (item.port_ok) begin
               // length is recorded even when the slot is rejected
               ctl.rec_we    = 1'b1;
               wr_rec.length = item.plen;
               if (item.slot_ok) begin
                  ctl.seq_we      = 1'b1;
                  ctl.mark_we     = 1'b1;
                  wr_rec.stamp    = item.tcount;
                  rsp.accepted    = 1'b1;
                  if (item.plen <= max_len) begin
                     if (item.fcount != next_count) begin
                        wr_rec.loss     = rd_rec.loss + 32'd1;
                        marks_out.valid = 1'b0;
                     end else begin
                        wr_rec.good     = rd_rec.good + 32'd1;
                        marks_out.valid = 1'b1;
                        rsp.frame_ok    = 1'b1;
                     end
                  end else begin
                     wr_rec.overlen  = rd_rec.overlen + 32'd1;
                     marks_out.valid = 1'b0;
                  end
               end
            end
         end
         REQ_QUERY: begin
            if (item.slot_ok && item.port_ok) begin
               rsp.accepted = 1'b1;
               if (!marks_in.processed) begin
                  ctl.rec_we  = 1'b1;
                  ctl.mark_we = 1'b1;
                  // unchanged tag since last period: data went stale
                  if (marks_in.valid && marks_in.last_valid &&
                      rd_rec.seen_tag == rd_rec.stamp) begin
                     marks_out.valid   = 1'b0;
                     rsp.stale_dropped = 1'b1;
                  end
                  marks_out.last_valid = marks_out.valid;
                  marks_out.processed  = 1'b1;
                  wr_rec.seen_tag      = rd_rec.stamp;
               end
            end
         end
         REQ_PERIOD: begin
            ctl.clr_processed = 1'b1;
            rsp.accepted      = 1'b1;
         end
         default: begin
         end
      endcase

      if (rsp.accepted && item.kind != REQ_PERIOD) begin
         rsp.port_data_valid   = marks_out.valid;
         rsp.port_time_tag     = wr_rec.stamp;
         rsp.port_frame_length = wr_rec.length;
         rsp.lost_frames       = wr_rec.loss;
         rsp.good_frames       = wr_rec.good;
         rsp.length_errors     = wr_rec.overlen;
      end
   end

endmodule

`default_nettype wire

// ===== src/frame_sequence_loss_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_sequence_loss_monitor
// per slot and port frame sequence checker with per port diagnostics
// ----------------------------------------------------------------------------
// Each word is handled in two steps: the accept edge reads the sequence memory
// and the port record memory (registered read), and the end of the execute state
// writes back the updated entries and loads the result register. A new word is taken
// only after the write back, so accesses to one entry never overlap; a full
// result register holds the item in its execute state until the result is
// taken. Both memories reset through per entry valid bits, so no clearing
// pass is needed and the block accepts words right after reset.
`default_nettype none

module frame_sequence_loss_monitor
   import fslm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [2:0]  req_slot,
   input  wire logic [4:0]  req_src_port_code,
   input  wire logic [3:0]  req_query_port,
   input  wire logic [15:0] req_frame_count,
   input  wire logic [15:0] req_payload_length,
   input  wire logic [31:0] req_time_count,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_accepted,
   output logic             rsp_frame_ok,
   output logic             rsp_port_data_valid,
   output logic             rsp_stale_dropped,
   output logic [31:0]      rsp_port_time_tag,
   output logic [15:0]      rsp_port_frame_length,
   output logic [31:0]      rsp_lost_frames,
   output logic [31:0]      rsp_good_frames,
   output logic [31:0]      rsp_length_errors,
   // register write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_max_frame_length
);

   fslm_state_type state_ff, state_in;

   logic         req_take;
   logic         out_free;
   logic         exec_go;

   // decoded request
   req_kind_type kind_w;
   logic [4:0]   code_m1;
   logic [3:0]   frm_port;
   logic [3:0]   sel_port;
   logic         slot_ok_w;
   logic         port_ok_w;
   item_type     item_w;
   item_type     item_ff;

   // memories and their valid bits
   logic [SEQ_DEPTH-1:0]  seq_vld_ff;
   logic [PORT_COUNT-1:0] rec_vld_ff;
   logic                  seq_hit_ff;
   logic                  rec_hit_ff;
   logic [15:0]           seq_rd_data;
   port_rec_type          rec_rd_data;
   logic [15:0]           prev_count;
   port_rec_type          rd_rec;

   // per port marks
   logic [PORT_COUNT-1:0] valid_mark_ff;
   logic [PORT_COUNT-1:0] last_valid_ff;
   logic [PORT_COUNT-1:0] processed_ff;
   mark_type              marks_rd;

   logic [15:0]  max_len_ff;

   port_rec_type wr_rec;
   mark_type     marks_wr;
   upd_ctl_type  ctl;
   rsp_type      rsp_w;
   rsp_type      rsp_ff;
   logic         rsp_valid_ff;

   // ---------------------------------------------------------------- decode
   assign kind_w   = req_kind_type'(req_type);
   assign code_m1  = req_src_port_code - 5'd1;
   // codes 0 and 1 both map to port 0
   assign frm_port = (req_src_port_code == 5'd0) ? 4'd0 : code_m1[4:1];
   assign sel_port = (kind_w == REQ_FRAME) ? frm_port : req_query_port;
   assign slot_ok_w = int'(req_slot) < SLOT_COUNT;
   assign port_ok_w = int'(sel_port) < PORT_COUNT;

   always_comb begin
      item_w         = '0;
      item_w.kind    = kind_w;
      item_w.slot_ok = slot_ok_w;
      item_w.port_ok = port_ok_w;
      item_w.port    = PORT_AW'(sel_port);
      item_w.seq_idx = SEQ_AW'(int'(req_slot) * PORT_COUNT + int'(frm_port));
      item_w.fcount  = req_frame_count;
      item_w.plen    = req_payload_length;
      item_w.tcount  = req_time_count;
   end

   // ---------------------------------------------------------------- control
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      exec_go   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_EXEC: exec_go   = out_free;
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // item held through its execute state
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_w;
      end
   end

   // config register, written only while idle
   assign csr_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_max_frame_length;
      end
   end

   // ---------------------------------------------------------------- memories
   fslm_ram #(
      .WIDTH (16),
      .DEPTH (SEQ_DEPTH),
      .AW    (SEQ_AW)
   ) u_seq_ram (
      .clock   (clock),
      .wr_en   (exec_go && ctl.seq_we),
      .wr_addr (item_ff.seq_idx),
      .wr_data (item_ff.fcount),
      .rd_en   (req_take),
      .rd_addr (item_w.seq_idx),
      .rd_data (seq_rd_data)
   );

   fslm_ram #(
      .WIDTH ($bits(port_rec_type)),
      .DEPTH (PORT_COUNT),
      .AW    (PORT_AW)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (exec_go && ctl.rec_we),
      .wr_addr (item_ff.port),
      .wr_data (wr_rec),
      .rd_en   (req_take),
      .rd_addr (item_w.port),
      .rd_data (rec_rd_data)
   );

   // valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_vld_ff <= '0;
         rec_vld_ff <= '0;
         seq_hit_ff <= 1'b0;
         rec_hit_ff <= 1'b0;
      end else begin
         if (req_take) begin
            seq_hit_ff <= slot_ok_w && port_ok_w && seq_vld_ff[item_w.seq_idx];
            rec_hit_ff <= port_ok_w && rec_vld_ff[item_w.port];
         end
         if (exec_go && ctl.seq_we) begin
            seq_vld_ff[item_ff.seq_idx] <= 1'b1;
         end
         if (exec_go && ctl.rec_we) begin
            rec_vld_ff[item_ff.port] <= 1'b1;
         end
      end
   end

   assign prev_count = seq_hit_ff ? seq_rd_data : 16'd0;
   assign rd_rec     = rec_hit_ff ? rec_rd_data : '0;

   // ---------------------------------------------------------------- marks
   always_comb begin
      marks_rd = '0;
      if (item_ff.port_ok) begin
         marks_rd.valid      = valid_mark_ff[item_ff.port];
         marks_rd.last_valid = last_valid_ff[item_ff.port];
         marks_rd.processed  = processed_ff[item_ff.port];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_mark_ff <= '0;
         last_valid_ff <= '0;
         processed_ff  <= '0;
      end else if (exec_go) begin
         if (ctl.clr_processed) begin
            processed_ff <= '0;
         end else if (ctl.mark_we) begin
            valid_mark_ff[item_ff.port] <= marks_wr.valid;
            last_valid_ff[item_ff.port] <= marks_wr.last_valid;
            processed_ff[item_ff.port]  <= marks_wr.processed;
         end
      end
   end

   // ---------------------------------------------------------------- modify
   fslm_update u_update (
      .item       (item_ff),
      .rd_rec     (rd_rec),
      .prev_count (prev_count),
      .marks_in   (marks_rd),
      .max_len    (max_len_ff),
      .wr_rec     (wr_rec),
      .marks_out  (marks_wr),
      .ctl        (ctl),
      .rsp        (rsp_w)
   );

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_ff <= rsp_w;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_accepted          = rsp_ff.accepted;
   assign rsp_frame_ok          = rsp_ff.frame_ok;
   assign rsp_port_data_valid   = rsp_ff.port_data_valid;
   assign rsp_stale_dropped     = rsp_ff.stale_dropped;
   assign rsp_port_time_tag     = rsp_ff.port_time_tag;
   assign rsp_port_frame_length = rsp_ff.port_frame_length;
   assign rsp_lost_frames       = rsp_ff.lost_frames;
   assign rsp_good_frames       = rsp_ff.good_frames;
   assign rsp_length_errors     = rsp_ff.length_errors;

   // ---------------------------------------------------------------- checks
   // every accepted word reaches its execute cycle
   a_take_exec: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_EXEC)
      else $error("accepted word did not enter execute");

   // a blocked result keeps the next item waiting in execute
   a_hold_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && rsp_valid && rsp_stall) |=> state_ff == ST_EXEC)
      else $error("item left execute while result was blocked");

   // execute always delivers a result word
   a_go_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> rsp_valid)
      else $error("execute without result");

   // a stale drop comes only from an accepted query
   a_stale_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stale_dropped) |-> (rsp_accepted && !rsp_frame_ok))
      else $error("stale drop on a non query result");

   // a good frame always leaves the port valid
   a_ok_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_ok) |-> (rsp_accepted && rsp_port_data_valid))
      else $error("good frame without valid port data");

endmodule

`default_nettype wire
